// File: hdl/rgb_to_hsv_convert_unit_defines.svh
// Assertion macros shared by the conversion unit. Each macro expects clk_i and
// rst_ni to be visible where it is used.
`ifndef RGB_TO_HSV_CONVERT_UNIT_DEFINES_SVH
`define RGB_TO_HSV_CONVERT_UNIT_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define RHC_ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rgb_to_hsv_convert_unit: check failed");

// Next-cycle implication, checked out of reset.
`define RHC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rgb_to_hsv_convert_unit: check failed");

`endif

// File: hdl/rhc_pkg.sv
`default_nettype none

package rhc_pkg;

  localparam int unsigned ChanW         = 8;
  localparam int unsigned HueW          = 13;
  localparam int unsigned HueQuotW      = 10;
  localparam int unsigned SatQuotW      = 8;
  localparam int unsigned HueNumW       = ChanW + HueQuotW;
  localparam int unsigned SatNumW       = 2 * ChanW;
  localparam int unsigned StepsPerStage = 2;
  localparam int unsigned DivStages     = HueQuotW / StepsPerStage;
  localparam int unsigned SatStages     = SatQuotW / StepsPerStage;

  localparam logic [HueW-1:0] HueSectorUnit = 13'd960;
  localparam logic [HueW-1:0] HueFullCircle = 13'd5760;

  typedef logic [ChanW-1:0] chan_t;

  typedef enum logic [1:0] {
    SectorRed,
    SectorGreen,
    SectorBlue
  } sector_e;

  // Register contents after the channel compare.
  typedef struct packed {
    chan_t   hi;
    chan_t   delta;
    sector_e sector;
    logic    neg;
    chan_t   abs_diff;
  } front_t;

  // Register contents along the divider stages. The word fields start out
  // holding the low dividend bits and fill up with quotient bits.
  typedef struct packed {
    chan_t               hi;
    chan_t               delta;
    sector_e             sector;
    logic                neg;
    chan_t               hue_rem;
    logic [HueQuotW-1:0] hue_word;
    chan_t               sat_rem;
    logic [SatQuotW-1:0] sat_word;
  } div_t;

endpackage

`default_nettype wire

// File: hdl/rhc_rgb_if.sv
`default_nettype none

interface rhc_rgb_if;
  logic                 valid;
  logic                 ready;
  rhc_pkg::chan_t       red;
  rhc_pkg::chan_t       green;
  rhc_pkg::chan_t       blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

`default_nettype wire

// File: hdl/rhc_hsv_if.sv
`default_nettype none

interface rhc_hsv_if;
  logic                       valid;
  logic                       ready;
  logic [rhc_pkg::HueW-1:0]   hue;
  rhc_pkg::chan_t             saturation;
  rhc_pkg::chan_t             brightness;
  logic                       hue_valid;

  modport source (output valid, output hue, output saturation, output brightness,
                  output hue_valid, input ready);
  modport sink   (input valid, input hue, input saturation, input brightness,
                  input hue_valid, output ready);
endinterface

`default_nettype wire

// File: hdl/rgb_to_hsv_convert_unit.sv
// RGB to HSV pixel converter.
// Requests arrive on pix_i (red, green, blue, 8 bits each) and results leave
// on hsv_o (hue in degrees times 16, saturation, brightness, hue_valid). Both
// channels use valid/ready; a request or a result moves at a rising clock edge
// where valid and ready are both high.
// The datapath is an eight-register pipeline: channel compare, constant
// multiply, five divider stages retiring two quotient bits each, and the
// output register that applies the hue sector and wraparound. Each pixel
// passes through these registers in that order and is presented from the
// output register.
// Throughput is one pixel per clock if not stalled. Each stage holds its own
// valid bit and advances when the next stage is empty or moving, so bubbles
// collapse and the block keeps taking requests while a finished result waits.
// When the receiver stalls, results pile up stage by stage; pix_i.ready drops
// only once all eight stages hold a pixel. Nothing is dropped or repeated.
// Reset (rst_ni low, asynchronous) empties every stage; no state survives
// between pixels, so the block is ready as soon as reset is released.
// Black pixels give hue 0 with hue_valid low; grey pixels give hue 0.
`default_nettype none

`include "rgb_to_hsv_convert_unit_defines.svh"

module rgb_to_hsv_convert_unit (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  rhc_rgb_if.sink   pix_i,
  rhc_hsv_if.source hsv_o
);

  typedef struct packed {
    logic [rhc_pkg::HueW-1:0] hue;
    rhc_pkg::chan_t           saturation;
    rhc_pkg::chan_t           brightness;
    logic                     hue_valid;
  } out_t;

  // Stage 1: find the largest and smallest channel, pick the sector and form
  // the signed channel difference that drives the hue.
  rhc_pkg::front_t  front_d, front_q;
  logic             front_v_q;
  logic             front_rdy;

  rhc_pkg::chan_t            mx_rg, mn_rg, lo;
  logic [rhc_pkg::ChanW:0]   sub;

  always_comb begin
    mx_rg = (pix_i.red > pix_i.green) ? pix_i.red : pix_i.green;
    mn_rg = (pix_i.red < pix_i.green) ? pix_i.red : pix_i.green;
    front_d.hi = (mx_rg > pix_i.blue) ? mx_rg : pix_i.blue;
    lo         = (mn_rg < pix_i.blue) ? mn_rg : pix_i.blue;
    front_d.delta = front_d.hi - lo;
    // Ties go to red first, then green.
    if (pix_i.red >= front_d.hi) begin
      front_d.sector = rhc_pkg::SectorRed;
      sub = {1'b0, pix_i.green} - {1'b0, pix_i.blue};
    end else if (pix_i.green >= front_d.hi) begin
      front_d.sector = rhc_pkg::SectorGreen;
      sub = {1'b0, pix_i.blue} - {1'b0, pix_i.red};
    end else begin
      front_d.sector = rhc_pkg::SectorBlue;
      sub = {1'b0, pix_i.red} - {1'b0, pix_i.green};
    end
    front_d.neg = sub[rhc_pkg::ChanW];
    front_d.abs_diff = front_d.neg ? (~sub[rhc_pkg::ChanW-1:0] + 1'b1)
                                   : sub[rhc_pkg::ChanW-1:0];
  end

  // Stage 2: the constant multiplies, 960*|diff| and 255*delta, done as
  // shift-and-subtract. Both quotients are known to fit their widths, so
  // the top dividend bits already form a partial remainder below the divisor.
  rhc_pkg::div_t                 div_d [rhc_pkg::DivStages+1];
  rhc_pkg::div_t                 div_q [rhc_pkg::DivStages+1];
  logic [rhc_pkg::DivStages:0]   div_v_q;
  logic [rhc_pkg::DivStages:0]   div_rdy;

  logic [rhc_pkg::HueNumW-1:0] hue_num;
  logic [rhc_pkg::SatNumW-1:0] sat_num;

  always_comb begin
    hue_num = {front_q.abs_diff, 10'd0} - {4'd0, front_q.abs_diff, 6'd0};
    sat_num = {front_q.delta, 8'd0} - {8'd0, front_q.delta};
    div_d[0].hi       = front_q.hi;
    div_d[0].delta    = front_q.delta;
    div_d[0].sector   = front_q.sector;
    div_d[0].neg      = front_q.neg;
    div_d[0].hue_rem  = hue_num[rhc_pkg::HueNumW-1:rhc_pkg::HueQuotW];
    div_d[0].hue_word = hue_num[rhc_pkg::HueQuotW-1:0];
    div_d[0].sat_rem  = sat_num[rhc_pkg::SatNumW-1:rhc_pkg::SatQuotW];
    div_d[0].sat_word = sat_num[rhc_pkg::SatQuotW-1:0];
  end

  // Divider stages: each retires two hue quotient bits (divisor delta) and,
  // in the first stages, two saturation quotient bits (divisor max).
  for (genvar k = 0; k < rhc_pkg::DivStages; k++) begin : g_div
    rhc_pkg::chan_t              hue_rem_c  [rhc_pkg::StepsPerStage+1];
    logic [rhc_pkg::HueQuotW-1:0] hue_word_c [rhc_pkg::StepsPerStage+1];
    logic                        hue_bit_c  [rhc_pkg::StepsPerStage];
    rhc_pkg::chan_t              sat_rem_n;
    logic [rhc_pkg::SatQuotW-1:0] sat_word_n;

    assign hue_rem_c[0]  = div_q[k].hue_rem;
    assign hue_word_c[0] = div_q[k].hue_word;

    for (genvar j = 0; j < rhc_pkg::StepsPerStage; j++) begin : g_hue_step
      rhc_div_step u_hue_step (
        .rem_i (hue_rem_c[j]),
        .den_i (div_q[k].delta),
        .bit_i (hue_word_c[j][rhc_pkg::HueQuotW-1]),
        .rem_o (hue_rem_c[j+1]),
        .q_o   (hue_bit_c[j])
      );
      assign hue_word_c[j+1] = {hue_word_c[j][rhc_pkg::HueQuotW-2:0], hue_bit_c[j]};
    end

    if (k < rhc_pkg::SatStages) begin : g_sat
      rhc_pkg::chan_t               sat_rem_c  [rhc_pkg::StepsPerStage+1];
      logic [rhc_pkg::SatQuotW-1:0] sat_word_c [rhc_pkg::StepsPerStage+1];
      logic                         sat_bit_c  [rhc_pkg::StepsPerStage];

      assign sat_rem_c[0]  = div_q[k].sat_rem;
      assign sat_word_c[0] = div_q[k].sat_word;

      for (genvar j = 0; j < rhc_pkg::StepsPerStage; j++) begin : g_sat_step
        rhc_div_step u_sat_step (
          .rem_i (sat_rem_c[j]),
          .den_i (div_q[k].hi),
          .bit_i (sat_word_c[j][rhc_pkg::SatQuotW-1]),
          .rem_o (sat_rem_c[j+1]),
          .q_o   (sat_bit_c[j])
        );
        assign sat_word_c[j+1] = {sat_word_c[j][rhc_pkg::SatQuotW-2:0], sat_bit_c[j]};
      end

      assign sat_rem_n  = sat_rem_c[rhc_pkg::StepsPerStage];
      assign sat_word_n = sat_word_c[rhc_pkg::StepsPerStage];
    end else begin : g_sat_hold
      // Saturation quotient is complete; carry it along unchanged.
      assign sat_rem_n  = div_q[k].sat_rem;
      assign sat_word_n = div_q[k].sat_word;
    end

    always_comb begin
      div_d[k+1]          = div_q[k];
      div_d[k+1].hue_rem  = hue_rem_c[rhc_pkg::StepsPerStage];
      div_d[k+1].hue_word = hue_word_c[rhc_pkg::StepsPerStage];
      div_d[k+1].sat_rem  = sat_rem_n;
      div_d[k+1].sat_word = sat_word_n;
    end
  end

  // Output stage: apply the sign and sector base, wrap negative hues, and
  // override black and grey pixels.
  out_t  out_d, out_q;
  logic  out_v_q;
  logic  out_rdy;

  rhc_pkg::div_t              last;
  logic [rhc_pkg::HueW-1:0]   base;
  logic [rhc_pkg::HueW:0]     hsum;

  always_comb begin
    last = div_q[rhc_pkg::DivStages];
    case (last.sector)
      rhc_pkg::SectorRed:   base = '0;
      rhc_pkg::SectorGreen: base = rhc_pkg::HueSectorUnit << 1;
      rhc_pkg::SectorBlue:  base = rhc_pkg::HueSectorUnit << 2;
      default:              base = '0;
    endcase
    if (last.neg) begin
      hsum = {1'b0, base} - {4'd0, last.hue_word};
    end else begin
      hsum = {1'b0, base} + {4'd0, last.hue_word};
    end
    if (last.hi == '0 || last.delta == '0) begin
      out_d.hue = '0;
    end else if (hsum[rhc_pkg::HueW]) begin
      out_d.hue = hsum[rhc_pkg::HueW-1:0] + rhc_pkg::HueFullCircle;
    end else begin
      out_d.hue = hsum[rhc_pkg::HueW-1:0];
    end
    out_d.saturation = (last.hi == '0) ? '0 : last.sat_word;
    out_d.brightness = last.hi;
    out_d.hue_valid  = (last.hi != '0);
  end

  // Flow control: a stage advances when it is empty or the next one does.
  assign out_rdy = !out_v_q || hsv_o.ready;
  for (genvar k = 0; k <= rhc_pkg::DivStages; k++) begin : g_rdy
    if (k == rhc_pkg::DivStages) begin : g_last
      assign div_rdy[k] = !div_v_q[k] || out_rdy;
    end else begin : g_mid
      assign div_rdy[k] = !div_v_q[k] || div_rdy[k+1];
    end
  end
  assign front_rdy   = !front_v_q || div_rdy[0];
  assign pix_i.ready = front_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_v_q <= 1'b0;
      div_v_q   <= '0;
      out_v_q   <= 1'b0;
    end else begin
      if (front_rdy) begin
        front_v_q <= pix_i.valid;
      end
      if (div_rdy[0]) begin
        div_v_q[0] <= front_v_q;
      end
      for (int unsigned k = 0; k < rhc_pkg::DivStages; k++) begin
        if (div_rdy[k+1]) begin
          div_v_q[k+1] <= div_v_q[k];
        end
      end
      if (out_rdy) begin
        out_v_q <= div_v_q[rhc_pkg::DivStages];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (front_rdy) begin
      front_q <= front_d;
    end
    for (int unsigned k = 0; k <= rhc_pkg::DivStages; k++) begin
      if (div_rdy[k]) begin
        div_q[k] <= div_d[k];
      end
    end
    if (out_rdy) begin
      out_q <= out_d;
    end
  end

  assign hsv_o.valid      = out_v_q;
  assign hsv_o.hue        = out_q.hue;
  assign hsv_o.saturation = out_q.saturation;
  assign hsv_o.brightness = out_q.brightness;
  assign hsv_o.hue_valid  = out_q.hue_valid;

  // A black pixel must come out with every field cleared.
  `RHC_ASSERT_IMPLIES(a_black_clear, out_v_q && !out_q.hue_valid,
                      out_q.hue == '0 && out_q.saturation == '0 && out_q.brightness == '0)
  // Hue always stays inside one full circle after the wrap.
  `RHC_ASSERT_IMPLIES(a_hue_range, out_v_q, out_q.hue < rhc_pkg::HueFullCircle)
  // Zero saturation means a grey pixel, whose hue is forced to zero.
  `RHC_ASSERT_IMPLIES(a_grey_hue, out_v_q && out_q.saturation == '0, out_q.hue == '0)
  // A finished pixel moving out of the divider must land in the output register.
  `RHC_ASSERT_NEXT(a_drain, div_v_q[rhc_pkg::DivStages] && out_rdy, out_v_q)

endmodule

`default_nettype wire

// File: hdl/rhc_div_step.sv
`default_nettype none

// One restoring division step: shift the next dividend bit into the partial
// remainder and subtract the divisor when it fits.
module rhc_div_step (
  input  wire rhc_pkg::chan_t rem_i,
  input  wire rhc_pkg::chan_t den_i,
  input  wire logic           bit_i,
  output rhc_pkg::chan_t      rem_o,
  output logic                q_o
);

  logic [rhc_pkg::ChanW:0] trial;
  logic [rhc_pkg::ChanW:0] diff;

  assign trial = {rem_i, bit_i};
  assign diff  = trial - {1'b0, den_i};
  assign q_o   = (trial >= {1'b0, den_i});
  assign rem_o = q_o ? diff[rhc_pkg::ChanW-1:0] : trial[rhc_pkg::ChanW-1:0];

endmodule

`default_nettype wire
